// ----- rtl/lslf_pkg.sv -----
`default_nettype none
// ============================================================================
// lslf_pkg
// Shared constants, codes and controller/datapath interface types for the
// least-squares line fit core.
// ============================================================================
package lslf_pkg;

    localparam int DEF_MAX_SAMPLES = 1024;
    localparam int DEF_SAMPLE_BITS = 16;

    // Fixed field widths of the stream words.
    localparam int SAMPLE_W  = 16;
    localparam int S_TDATA_W = 2 * SAMPLE_W;
    localparam int COEF_W    = 48;
    localparam int R2_W      = 17;
    localparam int FRAC_W    = 16;
    localparam int R2_ONE    = 65536;
    localparam int M_TDATA_W = ((2 * COEF_W + R2_W + 7) / 8) * 8;
    localparam int STATUS_W  = 2;

    typedef enum logic [STATUS_W-1:0] {
        FIT_OK       = 2'd0,
        FIT_X_CONST  = 2'd1,
        FIT_Y_CONST  = 2'd2,
        FIT_OVERFLOW = 2'd3
    } fit_status_t;

    // Products formed by the shared serial multiplier, in issue order.
    typedef enum logic [3:0] {
        MUL_N_SXX,
        MUL_SX_SX,
        MUL_N_SYY,
        MUL_SY_SY,
        MUL_N_SXY,
        MUL_SX_SY,
        MUL_SXX_SY,
        MUL_SX_SXY,
        MUL_NXY_NXY,
        MUL_DX_DY
    } mul_sel_t;

    // Quotients formed by the shared serial divider.
    typedef enum logic [1:0] {
        DIV_SLOPE,
        DIV_ICPT,
        DIV_R2
    } div_sel_t;

    typedef struct packed {
        logic        mul_start;
        mul_sel_t    mul_sel;
        logic        div_start;
        div_sel_t    div_sel;
        logic        out_load;
        logic        sums_clear;
        fit_status_t code;
    } lslf_cmd_t;

    typedef struct packed {
        logic mul_done;
        logic div_done;
        logic dx_le_zero;
        logic dy_le_zero;
        logic overflow;
    } lslf_stat_t;

endpackage
`default_nettype wire

// ----- rtl/lslf_accum.sv -----
`default_nettype none
// ============================================================================
// lslf_accum
// Running sample count and exact sums of x, y, x*x, y*y and x*y.
// ============================================================================
module lslf_accum #(
    parameter int   MAX_SAMPLES = lslf_pkg::DEF_MAX_SAMPLES,
    parameter int   SAMPLE_BITS = lslf_pkg::DEF_SAMPLE_BITS,
    localparam int  CNT_W       = $clog2(MAX_SAMPLES + 1),
    localparam int  S1_W        = SAMPLE_BITS + CNT_W,
    localparam int  S2_W        = 2 * SAMPLE_BITS + CNT_W - 1
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             sample_valid,
    input  wire logic [lslf_pkg::SAMPLE_W-1:0]    sample_x,
    input  wire logic [lslf_pkg::SAMPLE_W-1:0]    sample_y,
    input  wire logic                             clear,
    output logic      [CNT_W-1:0]                 count,
    output logic signed [S1_W-1:0]                sum_x,
    output logic signed [S1_W-1:0]                sum_y,
    output logic signed [S2_W-1:0]                sum_xx,
    output logic signed [S2_W-1:0]                sum_yy,
    output logic signed [S2_W-1:0]                sum_xy,
    output logic                                  overflow
);
    import lslf_pkg::*;

    logic signed [SAMPLE_BITS-1:0]   x;
    logic signed [SAMPLE_BITS-1:0]   y;
    logic signed [2*SAMPLE_BITS-1:0] xx;
    logic signed [2*SAMPLE_BITS-1:0] yy;
    logic signed [2*SAMPLE_BITS-1:0] xy;
    logic                            full;

    logic      [CNT_W-1:0]  count_reg;
    logic signed [S1_W-1:0] sum_x_reg;
    logic signed [S1_W-1:0] sum_y_reg;
    logic signed [S2_W-1:0] sum_xx_reg;
    logic signed [S2_W-1:0] sum_yy_reg;
    logic signed [S2_W-1:0] sum_xy_reg;
    logic                   overflow_reg;

    // Bits above SAMPLE_BITS are ignored; the rest is sign-extended.
    assign x  = sample_x[SAMPLE_BITS-1:0];
    assign y  = sample_y[SAMPLE_BITS-1:0];
    assign xx = x * x;
    assign yy = y * y;
    assign xy = x * y;

    assign full = (count_reg == CNT_W'(MAX_SAMPLES));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            sum_x_reg    <= '0;
            sum_y_reg    <= '0;
            sum_xx_reg   <= '0;
            sum_yy_reg   <= '0;
            sum_xy_reg   <= '0;
            overflow_reg <= 1'b0;
        end
        else if (clear)
        begin
            count_reg    <= '0;
            sum_x_reg    <= '0;
            sum_y_reg    <= '0;
            sum_xx_reg   <= '0;
            sum_yy_reg   <= '0;
            sum_xy_reg   <= '0;
            overflow_reg <= 1'b0;
        end
        else if (sample_valid)
        begin
            if (full)
            begin
                // A sample beyond capacity is dropped and poisons the set.
                overflow_reg <= 1'b1;
            end
            else
            begin
                count_reg  <= count_reg + CNT_W'(1);
                sum_x_reg  <= sum_x_reg + S1_W'(x);
                sum_y_reg  <= sum_y_reg + S1_W'(y);
                sum_xx_reg <= sum_xx_reg + S2_W'(xx);
                sum_yy_reg <= sum_yy_reg + S2_W'(yy);
                sum_xy_reg <= sum_xy_reg + S2_W'(xy);
            end
        end
    end

    assign count    = count_reg;
    assign sum_x    = sum_x_reg;
    assign sum_y    = sum_y_reg;
    assign sum_xx   = sum_xx_reg;
    assign sum_yy   = sum_yy_reg;
    assign sum_xy   = sum_xy_reg;
    assign overflow = overflow_reg;

endmodule
`default_nettype wire

// ----- rtl/lslf_div.sv -----
`default_nettype none
// ============================================================================
// lslf_div
// Restoring unsigned divider, one quotient bit per cycle, with a flag for
// rounding to nearest (ties away from zero).
// ============================================================================
module lslf_div #(
    parameter int NUM_W = 124,
    parameter int DEN_W = 108
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [DEN_W-1:0] den,
    output logic                  done,
    output logic      [NUM_W-1:0] quo,
    output logic                  round_up
);
    import lslf_pkg::*;

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] num_reg;
    logic [DEN_W-1:0] den_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             done_reg;

    logic [DEN_W:0]   shifted;
    logic [DEN_W:0]   trial;
    logic             fits;

    // The dividend shifts out at the top while quotient bits enter below.
    assign shifted = {rem_reg, num_reg[NUM_W-1]};
    assign trial   = shifted - {1'b0, den_reg};
    assign fits    = (shifted >= {1'b0, den_reg});

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= num;
            den_reg <= den;
            rem_reg <= '0;
        end
        else if (cnt_reg != '0)
        begin
            num_reg <= {num_reg[NUM_W-2:0], fits};
            rem_reg <= fits ? trial[DEN_W-1:0] : shifted[DEN_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg <= CNT_W'(NUM_W);
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quo      = num_reg;
    assign round_up = ({rem_reg, 1'b0} >= {1'b0, den_reg});

endmodule
`default_nettype wire

// ----- rtl/lslf_datapath.sv -----
`default_nettype none
// ============================================================================
// lslf_datapath
// Sums, serial multiplier, intermediate terms, divider and result register.
// ============================================================================
module lslf_datapath #(
    parameter int MAX_SAMPLES = lslf_pkg::DEF_MAX_SAMPLES,
    parameter int SAMPLE_BITS = lslf_pkg::DEF_SAMPLE_BITS
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               sample_valid,
    input  wire logic [lslf_pkg::SAMPLE_W-1:0]      sample_x,
    input  wire logic [lslf_pkg::SAMPLE_W-1:0]      sample_y,
    input  wire lslf_pkg::lslf_cmd_t                cmd,
    output lslf_pkg::lslf_stat_t                    stat,
    output logic signed [lslf_pkg::COEF_W-1:0]      slope,
    output logic signed [lslf_pkg::COEF_W-1:0]      intercept,
    output logic        [lslf_pkg::R2_W-1:0]        r_squared,
    output lslf_pkg::fit_status_t                   fit_status
);
    import lslf_pkg::*;

    localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
    localparam int S1_W   = SAMPLE_BITS + CNT_W;
    localparam int S2_W   = 2 * SAMPLE_BITS + CNT_W - 1;
    localparam int DW     = 2 * S1_W;        // magnitude width of every factor
    localparam int PW     = 2 * DW;          // product width
    localparam int NUM_W  = PW + FRAC_W;     // dividend width
    localparam int MCNT_W = $clog2(DW + 1);

    localparam logic [NUM_W:0] COEF_POS_LIM =
        {{(NUM_W + 2 - COEF_W){1'b0}}, {(COEF_W - 1){1'b1}}};
    localparam logic [NUM_W:0] COEF_NEG_LIM = COEF_POS_LIM + (NUM_W + 1)'(1);
    localparam logic [NUM_W:0] R2_LIM       = (NUM_W + 1)'(R2_ONE);

    // Running sums.
    logic      [CNT_W-1:0]  count;
    logic signed [S1_W-1:0] sum_x;
    logic signed [S1_W-1:0] sum_y;
    logic signed [S2_W-1:0] sum_xx;
    logic signed [S2_W-1:0] sum_yy;
    logic signed [S2_W-1:0] sum_xy;
    logic                   overflow;

    lslf_accum #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_accum (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_x     (sample_x),
        .sample_y     (sample_y),
        .clear        (cmd.sums_clear),
        .count        (count),
        .sum_x        (sum_x),
        .sum_y        (sum_y),
        .sum_xx       (sum_xx),
        .sum_yy       (sum_yy),
        .sum_xy       (sum_xy),
        .overflow     (overflow)
    );

    // Intermediate terms.
    logic signed [PW:0] t_reg;
    logic signed [DW:0] dx_reg;
    logic signed [DW:0] dy_reg;
    logic signed [DW:0] nxy_reg;
    logic signed [PW:0] bnum_reg;
    logic [PW-1:0]      den2_reg;

    // Multiplier operand selection.
    logic signed [DW:0] opa;
    logic signed [DW:0] opb;
    logic signed [DW:0] opa_abs;
    logic signed [DW:0] opb_abs;

    always_comb
    begin
        opa = '0;
        opb = '0;
        unique case (cmd.mul_sel)
            MUL_N_SXX:
            begin
                opa = (DW + 1)'(count);
                opb = (DW + 1)'(sum_xx);
            end
            MUL_SX_SX:
            begin
                opa = (DW + 1)'(sum_x);
                opb = (DW + 1)'(sum_x);
            end
            MUL_N_SYY:
            begin
                opa = (DW + 1)'(count);
                opb = (DW + 1)'(sum_yy);
            end
            MUL_SY_SY:
            begin
                opa = (DW + 1)'(sum_y);
                opb = (DW + 1)'(sum_y);
            end
            MUL_N_SXY:
            begin
                opa = (DW + 1)'(count);
                opb = (DW + 1)'(sum_xy);
            end
            MUL_SX_SY:
            begin
                opa = (DW + 1)'(sum_x);
                opb = (DW + 1)'(sum_y);
            end
            MUL_SXX_SY:
            begin
                opa = (DW + 1)'(sum_xx);
                opb = (DW + 1)'(sum_y);
            end
            MUL_SX_SXY:
            begin
                opa = (DW + 1)'(sum_x);
                opb = (DW + 1)'(sum_xy);
            end
            MUL_NXY_NXY:
            begin
                opa = nxy_reg;
                opb = nxy_reg;
            end
            MUL_DX_DY:
            begin
                opa = dx_reg;
                opb = dy_reg;
            end
            default:
            begin
                opa = '0;
                opb = '0;
            end
        endcase
    end

    assign opa_abs = opa[DW] ? -opa : opa;
    assign opb_abs = opb[DW] ? -opb : opb;

    // Shift-and-add multiplier on magnitudes, one multiplier bit per cycle.
    logic [DW-1:0]     mul_a_reg;
    logic [PW-1:0]     mul_p_reg;
    logic              mul_neg_reg;
    logic [MCNT_W-1:0] mul_cnt_reg;
    logic              mul_done_reg;
    logic [DW:0]       mul_add;
    logic signed [PW:0] prod_s;
    logic signed [PW:0] diff;

    assign mul_add = {1'b0, mul_p_reg[PW-1:DW]} + (mul_p_reg[0] ? {1'b0, mul_a_reg} : '0);
    assign prod_s  = mul_neg_reg ? -{1'b0, mul_p_reg} : {1'b0, mul_p_reg};
    assign diff    = t_reg - prod_s;

    always_ff @(posedge clk)
    begin
        if (cmd.mul_start)
        begin
            mul_a_reg   <= opa_abs[DW-1:0];
            mul_p_reg   <= {{DW{1'b0}}, opb_abs[DW-1:0]};
            mul_neg_reg <= opa[DW] ^ opb[DW];
        end
        else if (mul_cnt_reg != '0)
        begin
            mul_p_reg <= {mul_add, mul_p_reg[DW-1:1]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_cnt_reg  <= '0;
            mul_done_reg <= 1'b0;
        end
        else
        begin
            mul_done_reg <= 1'b0;
            if (cmd.mul_start)
            begin
                mul_cnt_reg <= MCNT_W'(DW);
            end
            else if (mul_cnt_reg != '0)
            begin
                mul_cnt_reg <= mul_cnt_reg - MCNT_W'(1);
                if (mul_cnt_reg == MCNT_W'(1))
                begin
                    mul_done_reg <= 1'b1;
                end
            end
        end
    end

    // Even steps park a product, odd steps subtract; the last keeps Dx*Dy.
    always_ff @(posedge clk)
    begin
        if (mul_done_reg)
        begin
            case (cmd.mul_sel) inside
                MUL_N_SXX, MUL_N_SYY, MUL_N_SXY, MUL_SXX_SY, MUL_NXY_NXY:
                    t_reg <= prod_s;
                MUL_SX_SX:  dx_reg   <= diff[DW:0];
                MUL_SY_SY:  dy_reg   <= diff[DW:0];
                MUL_SX_SY:  nxy_reg  <= diff[DW:0];
                MUL_SX_SXY: bnum_reg <= diff;
                MUL_DX_DY:  den2_reg <= mul_p_reg;
                default:    ;
            endcase
        end
    end

    // Divider operand selection.
    logic signed [DW:0] nxy_abs;
    logic signed [PW:0] bnum_abs;
    logic [NUM_W-1:0]   div_num;
    logic [PW-1:0]      div_den;
    logic               div_neg;
    logic               div_neg_reg;
    logic               div_done;
    logic [NUM_W-1:0]   div_quo;
    logic               div_round_up;

    assign nxy_abs  = nxy_reg[DW] ? -nxy_reg : nxy_reg;
    assign bnum_abs = bnum_reg[PW] ? -bnum_reg : bnum_reg;

    always_comb
    begin
        unique case (cmd.div_sel)
            DIV_SLOPE:
            begin
                div_num = NUM_W'(nxy_abs[DW-1:0]) << FRAC_W;
                div_den = PW'(dx_reg[DW-1:0]);
                div_neg = nxy_reg[DW];
            end
            DIV_ICPT:
            begin
                div_num = NUM_W'(bnum_abs[PW-1:0]) << FRAC_W;
                div_den = PW'(dx_reg[DW-1:0]);
                div_neg = bnum_reg[PW];
            end
            DIV_R2:
            begin
                div_num = NUM_W'(t_reg[PW-1:0]) << FRAC_W;
                div_den = den2_reg;
                div_neg = 1'b0;
            end
            default:
            begin
                div_num = '0;
                div_den = '0;
                div_neg = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            div_neg_reg <= div_neg;
        end
    end

    lslf_div #(
        .NUM_W (NUM_W),
        .DEN_W (PW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .num      (div_num),
        .den      (div_den),
        .done     (div_done),
        .quo      (div_quo),
        .round_up (div_round_up)
    );

    // Round, saturate to the field's range and apply the sign.
    logic [NUM_W:0]        q_round;
    logic [NUM_W:0]        q_lim;
    logic [NUM_W:0]        q_sat;
    logic [COEF_W-1:0]     coef_mag;
    logic [COEF_W-1:0]     coef_val;

    assign q_round  = {1'b0, div_quo} + (NUM_W + 1)'(div_round_up);
    assign q_lim    = (cmd.div_sel == DIV_R2) ? R2_LIM
                    : (div_neg_reg ? COEF_NEG_LIM : COEF_POS_LIM);
    assign q_sat    = (q_round > q_lim) ? q_lim : q_round;
    assign coef_mag = q_sat[COEF_W-1:0];
    assign coef_val = div_neg_reg ? (COEF_W'(0) - coef_mag) : coef_mag;

    logic [COEF_W-1:0] slope_reg;
    logic [COEF_W-1:0] icpt_reg;
    logic [R2_W-1:0]   r2_reg;

    always_ff @(posedge clk)
    begin
        if (div_done)
        begin
            unique case (cmd.div_sel)
                DIV_SLOPE: slope_reg <= coef_val;
                DIV_ICPT:  icpt_reg  <= coef_val;
                DIV_R2:    r2_reg    <= q_sat[R2_W-1:0];
                default:   ;
            endcase
        end
    end

    // Result word register; fields that the status code voids read as zero.
    logic [COEF_W-1:0] out_slope_reg;
    logic [COEF_W-1:0] out_icpt_reg;
    logic [R2_W-1:0]   out_r2_reg;
    fit_status_t       out_status_reg;
    logic              coef_ok;

    assign coef_ok = (cmd.code == FIT_OK) || (cmd.code == FIT_Y_CONST);

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_slope_reg  <= coef_ok ? slope_reg : '0;
            out_icpt_reg   <= coef_ok ? icpt_reg : '0;
            out_r2_reg     <= (cmd.code == FIT_OK) ? r2_reg : '0;
            out_status_reg <= cmd.code;
        end
    end

    assign slope      = out_slope_reg;
    assign intercept  = out_icpt_reg;
    assign r_squared  = out_r2_reg;
    assign fit_status = out_status_reg;

    assign stat.mul_done   = mul_done_reg;
    assign stat.div_done   = div_done;
    assign stat.dx_le_zero = dx_reg[DW] || (dx_reg == '0);
    assign stat.dy_le_zero = dy_reg[DW] || (dy_reg == '0);
    assign stat.overflow   = overflow;

endmodule
`default_nettype wire

// ----- rtl/lslf_ctrl.sv -----
`default_nettype none
// ============================================================================
// lslf_ctrl
// Sequencer: accepts samples, then steps the multiplier and divider through
// the fit and hands the result word to the output register.
// ============================================================================
module lslf_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    input  wire logic                  s_tlast,
    output logic                       s_tready,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output lslf_pkg::lslf_cmd_t        cmd,
    input  wire lslf_pkg::lslf_stat_t  stat
);
    import lslf_pkg::*;

    typedef enum logic [2:0] {
        ST_ACCUM,
        ST_MUL,
        ST_DIV,
        ST_HOLD,
        ST_LOAD
    } state_t;

    state_t    state_reg;
    state_t    state_next;
    lslf_cmd_t cmd_reg;
    lslf_cmd_t cmd_next;
    logic      m_valid_reg;
    logic      m_valid_next;

    always_comb
    begin
        state_next          = state_reg;
        cmd_next            = cmd_reg;
        cmd_next.mul_start  = 1'b0;
        cmd_next.div_start  = 1'b0;
        cmd_next.out_load   = 1'b0;
        cmd_next.sums_clear = 1'b0;
        m_valid_next        = m_valid_reg && !m_tready;

        unique case (state_reg)
            ST_ACCUM:
            begin
                if (s_tvalid && s_tlast)
                begin
                    state_next         = ST_MUL;
                    cmd_next.mul_start = 1'b1;
                    cmd_next.mul_sel   = MUL_N_SXX;
                end
            end
            ST_MUL:
            begin
                if (stat.mul_done)
                begin
                    unique case (cmd_reg.mul_sel)
                        MUL_SX_SXY:
                        begin
                            if (stat.overflow)
                            begin
                                cmd_next.code = FIT_OVERFLOW;
                                state_next    = ST_HOLD;
                            end
                            else if (stat.dx_le_zero)
                            begin
                                cmd_next.code = FIT_X_CONST;
                                state_next    = ST_HOLD;
                            end
                            else
                            begin
                                cmd_next.mul_start = 1'b1;
                                cmd_next.mul_sel   = MUL_NXY_NXY;
                            end
                        end
                        MUL_DX_DY:
                        begin
                            state_next         = ST_DIV;
                            cmd_next.div_start = 1'b1;
                            cmd_next.div_sel   = DIV_SLOPE;
                        end
                        default:
                        begin
                            cmd_next.mul_start = 1'b1;
                            cmd_next.mul_sel   = mul_sel_t'(cmd_reg.mul_sel + 4'd1);
                        end
                    endcase
                end
            end
            ST_DIV:
            begin
                if (stat.div_done)
                begin
                    unique case (cmd_reg.div_sel)
                        DIV_SLOPE:
                        begin
                            cmd_next.div_start = 1'b1;
                            cmd_next.div_sel   = DIV_ICPT;
                        end
                        DIV_ICPT:
                        begin
                            if (stat.dy_le_zero)
                            begin
                                cmd_next.code = FIT_Y_CONST;
                                state_next    = ST_HOLD;
                            end
                            else
                            begin
                                cmd_next.div_start = 1'b1;
                                cmd_next.div_sel   = DIV_R2;
                            end
                        end
                        DIV_R2:
                        begin
                            cmd_next.code = FIT_OK;
                            state_next    = ST_HOLD;
                        end
                        default:
                        begin
                            state_next = ST_HOLD;
                        end
                    endcase
                end
            end
            ST_HOLD:
            begin
                // Wait until the output register is empty or emptying.
                if (!m_valid_reg || m_tready)
                begin
                    cmd_next.out_load   = 1'b1;
                    cmd_next.sums_clear = 1'b1;
                    state_next          = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                m_valid_next = 1'b1;
                state_next   = ST_ACCUM;
            end
            default:
            begin
                state_next = ST_ACCUM;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_ACCUM;
            cmd_reg     <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cmd_reg     <= cmd_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_tready = (state_reg == ST_ACCUM);
    assign m_tvalid = m_valid_reg;
    assign cmd      = cmd_reg;

endmodule
`default_nettype wire

// ----- rtl/least_squares_line_fit_core.sv -----
`default_nettype none
// ============================================================================
// least_squares_line_fit_core
// Streaming least-squares straight-line fit with slope, intercept and r^2.
// ============================================================================
// Throughput: one sample word per cycle while a set is being accumulated.
// Fit: after the word marked last, the serial multiplier and then the
//   serial divider form the result word. Sets with an overflow or a
//   constant x skip the last two products and all divisions; a constant
//   y skips the r^2 division.
// Reset: asynchronous, active low; clears the sums, count and control; no
//   clearing pass is needed, so samples are taken from the first cycle.
// ============================================================================
module least_squares_line_fit_core #(
    parameter int MAX_SAMPLES = lslf_pkg::DEF_MAX_SAMPLES,
    parameter int SAMPLE_BITS = lslf_pkg::DEF_SAMPLE_BITS
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // Sample words.
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [lslf_pkg::S_TDATA_W-1:0]    s_tdata,   // sample_x, sample_y
    input  wire logic                              s_tlast,   // last_sample
    // Result words.
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [lslf_pkg::M_TDATA_W-1:0]         m_tdata,   // slope, intercept, r_squared
    output logic [lslf_pkg::STATUS_W-1:0]          m_tuser    // fit_status
);
    import lslf_pkg::*;

    localparam int PAD_W = M_TDATA_W - 2 * COEF_W - R2_W;

    lslf_cmd_t              cmd;
    lslf_stat_t             stat;
    logic                   sample_valid;
    logic signed [COEF_W-1:0] slope;
    logic signed [COEF_W-1:0] intercept;
    logic [R2_W-1:0]        r_squared;
    fit_status_t            fit_status;

    // A sample word is taken whenever the sequencer is in its accumulate
    // phase. The word marked last is accumulated like any other before the
    // fit starts, so the whole set is in the sums when the multiplier runs.
    assign sample_valid = s_tvalid && s_tready;

    // The sequencer drives the multiplier, the divider and the result
    // register through a command struct and reads back done and sign flags.
    // Input is held off during the fit; a finished result waits in its own
    // register, so accumulation of the next set can go on while the
    // downstream side stalls.
    lslf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    // The datapath holds exact integer sums; the fit is formed from
    // Dx = n*Sxx - Sx^2, Dy = n*Syy - Sy^2 and Nxy = n*Sxy - Sx*Sy, and the
    // quotients are rounded to nearest with ties away from zero.
    lslf_datapath #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_x     (s_tdata[SAMPLE_W-1:0]),
        .sample_y     (s_tdata[2*SAMPLE_W-1:SAMPLE_W]),
        .cmd          (cmd),
        .stat         (stat),
        .slope        (slope),
        .intercept    (intercept),
        .r_squared    (r_squared),
        .fit_status   (fit_status)
    );

    assign m_tdata = {{PAD_W{1'b0}}, r_squared, intercept, slope};
    assign m_tuser = fit_status;

endmodule
`default_nettype wire

// ----- dv/testbench.sv -----
`timescale 1ns / 100ps
// ============================================================================
// testbench
// Self-checking bench for the least-squares line fit core. Sample words are
// streamed in sets, each closed by a word with tlast set. A predictor inside
// the bench keeps its own exact sums and computes slope, intercept, r squared
// and status for every set. Each result word is compared field by field with
// the oldest pending fit.
// ============================================================================
module testbench;

    import lslf_pkg::*;

    localparam int SET_LIMIT    = DEF_MAX_SAMPLES;
    // The drain wait at the end allows for the time from the last word of a
    // set to its result.
    localparam int DRAIN_CYCLES = 1500;
    localparam int HOLD_CYCLES  = 3000;

    // One expected fit, with the fields in the order they sit in the result word.
    typedef struct {
        logic [COEF_W-1:0] slope;
        logic [COEF_W-1:0] intercept;
        logic [R2_W-1:0]   r2;
        fit_status_t       status;
    } fit_result_t;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;   // sample_x, sample_y
    logic                 s_tlast;   // last_sample
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;   // slope, intercept, r_squared
    logic [STATUS_W-1:0]  m_tuser;   // fit_status

    // Running sums of the set that is being collected, as the predictor sees them.
    int unsigned acc_n;
    longint      acc_x, acc_y, acc_xx, acc_yy, acc_xy;
    bit          acc_dropped;

    fit_result_t pending_fits[$];

    int mismatches    = 0;
    int words_sent    = 0;
    int sets_sent     = 0;
    int fits_checked  = 0;
    int status_seen[4] = '{0, 0, 0, 0};

    // The idling controls. The hold-off request is picked up by the ready process.
    bit src_gaps_on    = 1'b1;
    bit sink_stalls_on = 1'b1;
    int hold_off_req   = 0;

    int corner_vals[5] = '{-32768, -32767, 0, 32766, 32767};

    least_squares_line_fit_core i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #(5_000_000);
        $display("[least_squares_line_fit_core] ERROR");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // This is the quotient of two magnitudes. It is rounded to nearest with
    // ties away from zero, and then clipped to cap.
    function automatic logic [127:0] round_quotient(logic [127:0] num, logic [127:0] den,
                                                    logic [127:0] cap);
        logic [127:0] q;
        logic [127:0] r;
        q = num / den;
        r = num % den;
        if (r >= den - r)
            q = q + 1;
        return (q > cap) ? cap : q;
    endfunction

    // The magnitude over den is turned into signed Q31.16. The negative side
    // saturates one step further out than the positive side.
    function automatic logic [COEF_W-1:0] q16_coef(logic [127:0] mag, bit neg,
                                                   logic [127:0] den);
        logic [127:0] cap;
        logic [127:0] q;
        cap = (128'd1 << (COEF_W - 1)) - (neg ? 128'd0 : 128'd1);
        q = round_quotient(mag << FRAC_W, den, cap);
        if (neg)
            q = -q;
        return q[COEF_W-1:0];
    endfunction

    // An accepted sample word is added to the sums. On the last word of a set,
    // the fit that the core must return is queued, and the sums are cleared.
    function automatic void fold_sample(logic signed [SAMPLE_W-1:0] x,
                                        logic signed [SAMPLE_W-1:0] y, bit last);
        longint              xl, yl, n, dx, dy, nxy;
        logic signed [127:0] w_xx, w_y, w_x, w_xy, bnum;
        logic [127:0]        nmag, bmag, dxw, dyw, r2q;
        bit                  bneg;
        fit_result_t         fit;
        xl = x;
        yl = y;
        // A word that arrives when the set already holds the limit is dropped.
        // The set then ends as an overflow.
        if (acc_n >= SET_LIMIT)
            acc_dropped = 1'b1;
        else
        begin
            acc_n++;
            acc_x  += xl;
            acc_y  += yl;
            acc_xx += xl * xl;
            acc_yy += yl * yl;
            acc_xy += xl * yl;
        end
        if (!last)
            return;

        n   = acc_n;
        dx  = n * acc_xx - acc_x * acc_x;
        dy  = n * acc_yy - acc_y * acc_y;
        nxy = n * acc_xy - acc_x * acc_y;
        fit.slope     = '0;
        fit.intercept = '0;
        fit.r2        = '0;
        fit.status    = FIT_OK;

        // The status codes have a fixed priority: overflow first, then
        // constant x, then constant y.
        if (acc_dropped)
            fit.status = FIT_OVERFLOW;
        else if (dx <= 0)
            fit.status = FIT_X_CONST;
        else
        begin
            w_xx = acc_xx;
            w_y  = acc_y;
            w_x  = acc_x;
            w_xy = acc_xy;
            bnum = w_xx * w_y - w_x * w_xy;
            bneg = bnum < 0;
            bmag = bneg ? -bnum : bnum;
            nmag = (nxy < 0) ? -nxy : nxy;
            dxw  = dx;
            fit.slope     = q16_coef(nmag, nxy < 0, dxw);
            fit.intercept = q16_coef(bmag, bneg, dxw);
            if (dy <= 0)
                fit.status = FIT_Y_CONST;
            else
            begin
                // r squared is Nxy squared over Dx times Dy, in Q1.16.
                dyw = dy;
                r2q = round_quotient((nmag * nmag) << FRAC_W, dxw * dyw, R2_ONE);
                fit.r2 = r2q[R2_W-1:0];
            end
        end
        pending_fits.push_back(fit);
        status_seen[fit.status]++;
        sets_sent++;

        acc_n       = 0;
        acc_x       = 0;
        acc_y       = 0;
        acc_xx      = 0;
        acc_yy      = 0;
        acc_xy      = 0;
        acc_dropped = 1'b0;
    endfunction

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------

    task automatic report_mismatch(string msg);
        mismatches++;
        $display("%0t ns: mismatch: %s", $time, msg);
    endtask

    task automatic check_field(string field, logic [63:0] got, logic [63:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s is %0h, expected %0h",
                                      fits_checked, field, got, want));
    endtask

    // Result words are sampled at the rising edge. The bench drives m_tready
    // only on the falling edge, so its value is stable here.
    always @(posedge clk)
    begin
        fit_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_fits.size() == 0)
                report_mismatch("result word arrived with no fit pending");
            else
            begin
                want = pending_fits.pop_front();
                check_field("slope", m_tdata[COEF_W-1:0], want.slope);
                check_field("intercept", m_tdata[2*COEF_W-1:COEF_W], want.intercept);
                check_field("r_squared", m_tdata[2*COEF_W+R2_W-1:2*COEF_W], want.r2);
                check_field("fit_status", m_tuser, want.status);
                fits_checked++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver
    // ------------------------------------------------------------------------

    // The receiver stalls in random bursts while stalls are enabled. A hold-off
    // request keeps m_tready low for a counted stretch. During that time the
    // sender keeps offering words, so the core fills up.
    initial
    begin
        int stall;
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_req > 0)
            begin
                stall = hold_off_req;
                hold_off_req = 0;
                m_tready <= 1'b0;
                repeat (stall) @(negedge clk);
                m_tready <= 1'b1;
            end
            else if (sink_stalls_on && $urandom_range(0, 5) == 0)
            begin
                stall = $urandom_range(1, 8);
                m_tready <= 1'b0;
                repeat (stall) @(negedge clk);
                m_tready <= 1'b1;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------------

    // One sample word is offered and held until it is accepted. tvalid is left
    // high afterwards. The next call either puts up new data on the next falling
    // edge or opens a gap in which tvalid is low before it goes high again.
    task automatic send_sample(logic signed [SAMPLE_W-1:0] x, logic signed [SAMPLE_W-1:0] y,
                               bit last);
        int gap;
        if (src_gaps_on && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 8);
            repeat (gap)
            begin
                @(negedge clk);
                s_tvalid <= 1'b0;
            end
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= {y, x};
        s_tlast  <= last;
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        fold_sample(x, y, last);
        words_sent++;
    endtask

    function automatic int random_set_size();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return 1;
        if (r <= 2)
            return $urandom_range(13, 64);
        return $urandom_range(2, 12);
    endfunction

    // A set is generated in one of several shapes. These are full random
    // data, a noisy line, constant x, constant y, tiny values near zero, and
    // values taken only from the ends of the range and zero.
    task automatic send_random_set(int size);
        int shape, slope_k, offset, x0, y0, xv, yv, k;
        shape   = $urandom_range(0, 9);
        x0      = $urandom_range(0, 65535) - 32768;
        y0      = $urandom_range(0, 65535) - 32768;
        slope_k = $urandom_range(0, 16) - 8;
        offset  = $urandom_range(0, 2000) - 1000;
        for (k = 0; k < size; k++)
        begin
            xv = $urandom_range(0, 65535) - 32768;
            yv = $urandom_range(0, 65535) - 32768;
            case (shape)
                4, 5:
                begin
                    xv = $urandom_range(0, 8191) - 4096;
                    yv = slope_k * xv + offset + $urandom_range(0, 64) - 32;
                    if (yv > 32767)
                        yv = 32767;
                    if (yv < -32768)
                        yv = -32768;
                end
                6: xv = x0;
                7: yv = y0;
                8:
                begin
                    xv = $urandom_range(0, 8) - 4;
                    yv = $urandom_range(0, 8) - 4;
                end
                9:
                begin
                    xv = corner_vals[$urandom_range(0, 4)];
                    yv = corner_vals[$urandom_range(0, 4)];
                end
                default: ;
            endcase
            send_sample(xv[15:0], yv[15:0], k == size - 1);
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // These sets have no usable fit: a single sample, constant x, constant y,
    // and both at once, where constant x takes priority.
    task automatic test_degenerate_sets();
        send_sample(0, 0, 1'b1);
        send_sample(5, 1, 1'b0);
        send_sample(5, 7, 1'b0);
        send_sample(5, -32768, 1'b1);
        send_sample(-3, 9, 1'b0);
        send_sample(4, 9, 1'b0);
        send_sample(100, 9, 1'b1);
        send_sample(2, 2, 1'b0);
        send_sample(2, 2, 1'b1);
    endtask

    // These are full-scale lines in both directions. Two of them are steep
    // lines near the ends of the x range, which give the largest intercepts the
    // inputs allow. The last set has fractional results with mixed signs, so
    // rounding is exercised.
    task automatic test_extreme_sets();
        send_sample(-32768, -32768, 1'b0);
        send_sample(32767, 32767, 1'b1);
        send_sample(-32768, 32767, 1'b0);
        send_sample(32767, -32768, 1'b1);
        send_sample(-32768, -32768, 1'b0);
        send_sample(-32767, 32767, 1'b0);
        send_sample(-32767, 32767, 1'b1);
        send_sample(32767, -32768, 1'b0);
        send_sample(32766, 32767, 1'b1);
        send_sample(0, 0, 1'b0);
        send_sample(3, 1, 1'b0);
        send_sample(6, 1, 1'b0);
        send_sample(-1, -2, 1'b1);
    endtask

    // This set has one word more than the limit and has constant x, so
    // overflow must win. The small set at the end shows that the sums were
    // cleared after the overflow.
    task automatic test_sample_limit();
        int k;
        for (k = 0; k <= SET_LIMIT; k++)
            send_sample(7, 16'($urandom), k == SET_LIMIT);
        send_sample(1, 1, 1'b0);
        send_sample(2, 3, 1'b0);
        send_sample(3, 2, 1'b1);
    endtask

    // The receiver holds off for a long stretch. Meanwhile several sets are
    // offered, so the finished result backs up and the input stalls.
    task automatic test_output_hold_off();
        hold_off_req = HOLD_CYCLES;
        send_random_set(4);
        send_random_set(7);
        send_random_set(30);
    endtask

    task automatic test_random_sets(int target_words, bit idling);
        int start;
        src_gaps_on    = idling;
        sink_stalls_on = idling;
        start = words_sent;
        while (words_sent - start < target_words)
            send_random_set(random_set_size());
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------

    initial
    begin
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tlast     = 1'b0;
        acc_n       = 0;
        acc_x       = 0;
        acc_y       = 0;
        acc_xx      = 0;
        acc_yy      = 0;
        acc_xy      = 0;
        acc_dropped = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_degenerate_sets();
        test_extreme_sets();
        test_sample_limit();
        test_output_hold_off();
        test_random_sets(300, 1'b1);
        test_random_sets(100, 1'b0);

        @(negedge clk);
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;

        while (pending_fits.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d sample words in %0d sets, %0d results checked.",
                 words_sent, sets_sent, fits_checked);
        $display("Sets by outcome: %0d fitted, %0d constant x, %0d constant y, %0d overflow.",
                 status_seen[FIT_OK], status_seen[FIT_X_CONST], status_seen[FIT_Y_CONST],
                 status_seen[FIT_OVERFLOW]);
        if (mismatches == 0 && pending_fits.size() == 0)
            $display("[least_squares_line_fit_core] OK");
        else
            $display("[least_squares_line_fit_core] ERROR");
        $finish;
    end

endmodule
